@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while rst_n is low.
`define MTSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtsl check failed");

// Same, with a caller-supplied message.
`define MTSL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ hdl/mtsl_pkg.sv @@
`timescale 1ns / 1ps
package mtsl_pkg;

  localparam int LIST_DEPTH_DEF = 1024;
  localparam int VAL_W          = 32;
  localparam int MED_W          = VAL_W + 1;
  localparam int CMD_W          = 2;
  localparam int STAT_W         = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOPART = 2'd2;

  typedef struct packed {
    logic                     done;
    logic [STAT_W-1:0]        status;
    logic signed [MED_W-1:0]  median;
  } srch_rsp_t;

endpackage

@@ hdl/mtsl_ram.sv @@
`timescale 1ns / 1ps
module mtsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/mtsl_search.sv @@
`timescale 1ns / 1ps
module mtsl_search #(
  parameter int LIST_DEPTH = mtsl_pkg::LIST_DEPTH_DEF,
  localparam int CW = $clog2(LIST_DEPTH + 1),
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [CW-1:0]              len_a,
  input  logic [CW-1:0]              len_b,
  output logic [AW-1:0]              addr_a,
  output logic [AW-1:0]              addr_b,
  input  logic [mtsl_pkg::VAL_W-1:0] data_a,
  input  logic [mtsl_pkg::VAL_W-1:0] data_b,
  output mtsl_pkg::srch_rsp_t        rsp,
  input  logic                       take
);
  import mtsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_RD0, S_RD1, S_EVAL, S_SUM, S_DONE
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           m_r, n_r, i_r, j_r, tl_r;
  logic signed [CW:0]      lo_r, hi_r;
  logic                    odd_r;
  logic [VAL_W-1:0]        al_r, bl_r, lmax_r, rmin_r;
  logic [STAT_W-1:0]       status_r;
  logic signed [MED_W-1:0] median_r;

  logic [CW:0]     total;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid;
  logic [CW-1:0]   i_dec, j_dec;
  logic            al_ok, ar_ok, bl_ok, br_ok, a_fits, b_fits;
  logic [VAL_W-1:0] lmax_nxt, rmin_nxt;

  assign total   = {1'b0, len_a} + {1'b0, len_b};
  assign mid_sum = {1'b0, lo_r[CW-1:0]} + {1'b0, hi_r[CW-1:0]};
  assign mid     = mid_sum[CW:1];
  assign i_dec   = i_r - 1'b1;
  assign j_dec   = j_r - 1'b1;

  // Left neighbors on the first read, right neighbors on the second.
  assign addr_a = (state_r == S_RD0) ? i_dec[AW-1:0] : i_r[AW-1:0];
  assign addr_b = (state_r == S_RD0) ? j_dec[AW-1:0] : j_r[AW-1:0];

  always_comb begin
    al_ok  = (i_r != '0);
    ar_ok  = (i_r < m_r);
    bl_ok  = (j_r != '0);
    br_ok  = (j_r < n_r);
    a_fits = !al_ok || !br_ok || ($signed(al_r) <= $signed(data_b));
    b_fits = !bl_ok || !ar_ok || ($signed(bl_r) <= $signed(data_a));
    if (!al_ok) begin
      lmax_nxt = bl_r;
    end else if (!bl_ok) begin
      lmax_nxt = al_r;
    end else begin
      lmax_nxt = ($signed(al_r) > $signed(bl_r)) ? al_r : bl_r;
    end
    if (!ar_ok) begin
      rmin_nxt = data_b;
    end else if (!br_ok) begin
      rmin_nxt = data_a;
    end else begin
      rmin_nxt = ($signed(data_a) < $signed(data_b)) ? data_a : data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            m_r   <= len_a;
            n_r   <= len_b;
            lo_r  <= '0;
            hi_r  <= $signed({1'b0, len_a});
            odd_r <= total[0];
            tl_r  <= CW'((total + 1'b1) >> 1);
            if (total == '0) begin
              status_r <= STAT_EMPTY;
              median_r <= '0;
              state_r  <= S_DONE;
            end else begin
              state_r  <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (lo_r > hi_r) begin
            status_r <= STAT_NOPART;
            median_r <= '0;
            state_r  <= S_DONE;
          end else begin
            i_r     <= mid;
            j_r     <= tl_r - mid;
            state_r <= S_RD0;
          end
        end
        S_RD0: begin
          state_r <= S_RD1;
        end
        S_RD1: begin
          // hold the left neighbors while the right ones are read
          al_r    <= data_a;
          bl_r    <= data_b;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (a_fits && b_fits) begin
            lmax_r  <= lmax_nxt;
            rmin_r  <= rmin_nxt;
            state_r <= S_SUM;
          end else begin
            if (!a_fits) begin
              hi_r <= $signed({1'b0, i_r} - 1'b1);
            end else begin
              lo_r <= $signed({1'b0, i_r} + 1'b1);
            end
            state_r <= S_CALC;
          end
        end
        S_SUM: begin
          status_r <= STAT_OK;
          if (odd_r) begin
            median_r <= $signed({lmax_r, 1'b0});
          end else begin
            median_r <= $signed({lmax_r[VAL_W-1], lmax_r})
                      + $signed({rmin_r[VAL_W-1], rmin_r});
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = (state_r == S_DONE);
  assign rsp.status = status_r;
  assign rsp.median = median_r;

endmodule

@@ hdl/median_of_two_sorted_lists.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                          | Direction
// input    | in_valid in_ready in_command in_value          | in
// result   | out_valid out_ready out_median_doubled         | out
//          | out_status out_dropped                         |
//
// A push item appends its value to its list unless it is full. A compute item
// searches the shorter list in floor(log2(m+1))+1 steps at most for a shorter
// length m, then finishes and hands over (no steps when both lists are empty);
// each step needs two reads from the single read port of each list RAM.
// Reset clears the counts and the overflow flag; the list RAMs are not cleared.
// Input stalls while a compute item is in flight; pushes keep flowing while a
// result waits in the output register.
module median_of_two_sorted_lists #(
  parameter int LIST_DEPTH = mtsl_pkg::LIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mtsl_pkg::CMD_W-1:0]        in_command,
  input  logic signed [mtsl_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mtsl_pkg::MED_W-1:0] out_median_doubled,
  output logic [mtsl_pkg::STAT_W-1:0]       out_status,
  output logic                              out_dropped
);
  import mtsl_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [CW-1:0]           first_cnt_r, second_cnt_r;
  logic                    ovf_r, drop_r, swap_r, busy_r;
  logic                    out_valid_r, out_drop_r;
  logic [STAT_W-1:0]       out_status_r;
  logic signed [MED_W-1:0] out_med_r;

  logic            in_acc, push_a, push_b, compute, take, swap_nxt;
  logic            we_a, we_b;
  logic [CW-1:0]   len_a, len_b;
  logic [AW-1:0]   addr_a, addr_b, raddr_first, raddr_second;
  logic [VAL_W-1:0] rdata_first, rdata_second, data_a, data_b;
  srch_rsp_t       rsp;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign push_a   = in_acc && (in_command == CMD_PUSH_A);
  assign push_b   = in_acc && (in_command == CMD_PUSH_B);
  assign compute  = in_acc && (in_command == CMD_COMPUTE);
  assign we_a     = push_a && (first_cnt_r < CW'(LIST_DEPTH));
  assign we_b     = push_b && (second_cnt_r < CW'(LIST_DEPTH));

  // Search the shorter list; ties go to the first.
  assign swap_nxt = first_cnt_r > second_cnt_r;
  assign len_a    = swap_nxt ? second_cnt_r : first_cnt_r;
  assign len_b    = swap_nxt ? first_cnt_r : second_cnt_r;

  assign raddr_first  = swap_r ? addr_b : addr_a;
  assign raddr_second = swap_r ? addr_a : addr_b;
  assign data_a       = swap_r ? rdata_second : rdata_first;
  assign data_b       = swap_r ? rdata_first : rdata_second;

  assign take = rsp.done && (!out_valid_r || out_ready);

  mtsl_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (first_cnt_r[AW-1:0]),
    .wdata (in_value),
    .raddr (raddr_first),
    .rdata (rdata_first)
  );

  mtsl_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (second_cnt_r[AW-1:0]),
    .wdata (in_value),
    .raddr (raddr_second),
    .rdata (rdata_second)
  );

  mtsl_search #(.LIST_DEPTH(LIST_DEPTH)) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (compute),
    .len_a  (len_a),
    .len_b  (len_b),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (data_a),
    .data_b (data_b),
    .rsp    (rsp),
    .take   (take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (we_a) begin
        first_cnt_r <= first_cnt_r + 1'b1;
      end
      if (we_b) begin
        second_cnt_r <= second_cnt_r + 1'b1;
      end
      if ((push_a && !we_a) || (push_b && !we_b)) begin
        ovf_r <= 1'b1;
      end
      if (compute) begin
        // drop both lists; the search works from the latched lengths
        first_cnt_r  <= '0;
        second_cnt_r <= '0;
        ovf_r        <= 1'b0;
        drop_r       <= ovf_r;
        swap_r       <= swap_nxt;
        busy_r       <= 1'b1;
      end
      if (take) begin
        busy_r       <= 1'b0;
        out_valid_r  <= 1'b1;
        out_med_r    <= rsp.median;
        out_status_r <= rsp.status;
        out_drop_r   <= drop_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_med_r;
  assign out_status         = out_status_r;
  assign out_dropped        = out_drop_r;

endmodule

@@ hdl/mtsl_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtsl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [mtsl_pkg::CMD_W-1:0]        in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mtsl_pkg::MED_W-1:0] out_median_doubled,
  input logic [mtsl_pkg::STAT_W-1:0]       out_status
);
  import mtsl_pkg::*;

  // A stalled result holds.
  `MTSL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_median_doubled))

  // Error and empty results carry a zero median.
  `MTSL_ASSERT_MSG(a_err_zero, out_valid && out_status != STAT_OK |-> out_median_doubled == '0, "nonzero median on error status")

  // A compute item blocks input while it searches.
  `MTSL_ASSERT(a_busy, in_valid && in_ready && in_command == CMD_COMPUTE |=> !in_ready)

  // A push item never produces a result on its own.
  `MTSL_ASSERT(a_push_quiet, !out_valid && in_ready |=> !out_valid || $past(in_ready) == 1'b0 || !in_ready || $past(out_valid))

endmodule

bind median_of_two_sorted_lists mtsl_checker u_mtsl_checker (.*);
